@@ sv/tac_pkg.sv @@
package tac_pkg;

   // converter and entry sizing
   localparam int unsigned ADC_BITS   = 10;
   localparam int unsigned MAX_DIGITS = 3;
   localparam int unsigned TEMP_SCALE = 150;

   localparam logic [7:0] LIMIT_RESET = 8'd100;

   // controller modes
   typedef enum logic [1:0] {
      MODE_MAIN  = 2'd0,
      MODE_ALARM = 2'd1,
      MODE_KEY   = 2'd2,
      MODE_SER   = 2'd3
   } mode_type;

   // event kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_KEY    = 2'd1;
   localparam logic [1:0] KIND_SERIAL = 2'd2;

   // keypad codes
   localparam logic [3:0] KEY_ZERO   = 4'd10;
   localparam logic [3:0] KEY_SILENCE = 4'd12;
   localparam logic [3:0] KEY_TOGGLE = 4'd13;
   localparam logic [3:0] KEY_ENTER  = 4'd15;

   // serial characters
   localparam logic [7:0] CHAR_GO     = 8'h47;
   localparam logic [7:0] CHAR_STOP   = 8'h53;
   localparam logic [7:0] CHAR_OK     = 8'h4F;
   localparam logic [7:0] CHAR_CANCEL = 8'h43;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;

   typedef struct packed {
      logic [1:0]          kind;
      logic [ADC_BITS-1:0] sample;
      logic [3:0]          key_code;
      logic [7:0]          rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] temperature;
      logic [7:0] limit;
      logic       alarm_enabled;
      logic       buzzer;
   } rsp_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] temp;
      logic [7:0] limit;
      logic       enable;
      logic       buzzer;
      logic [1:0] digit_count;
      logic [7:0] entry_value;
   } state_type;

endpackage

@@ sv/temperature_alarm_controller_core.sv @@
// path: a transaction taken into the input register gives its status through the status register
// throughput: one transaction per cycle while the status output is not stalled, set by the
// combinational state update between the input register and the status register
// reset: synchronous, active high; main mode, limit 100, alarm enabled,
// buzzer off, both registers empty
module temperature_alarm_controller_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tac_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tac_pkg::rsp_type rsp_data
);
   import tac_pkg::*;

   req_type   in_data_ff;
   logic      in_vld_ff;
   logic      in_vld_in;
   state_type state_ff;
   state_type state_in;
   state_type step_nxt;
   rsp_type   out_data_ff;
   logic      out_vld_ff;
   logic      out_vld_in;
   logic      advance;
   logic      req_take;

   // handshake control
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);

   tac_step u_step (
      .item (in_data_ff),
      .cur  (state_ff),
      .nxt  (step_nxt)
   );

   assign state_in = advance ? step_nxt : state_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= MODE_MAIN;
         state_ff.temp        <= 8'd0;
         state_ff.limit       <= LIMIT_RESET;
         state_ff.enable      <= 1'b1;
         state_ff.buzzer      <= 1'b0;
         state_ff.digit_count <= 2'd0;
         state_ff.entry_value <= 8'd0;
      end else begin
         state_ff <= state_in;
      end
   end

   // status register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      if (advance) begin
         out_data_ff.mode          <= step_nxt.mode;
         out_data_ff.temperature   <= step_nxt.temp;
         out_data_ff.limit         <= step_nxt.limit;
         out_data_ff.alarm_enabled <= step_nxt.enable;
         out_data_ff.buzzer        <= step_nxt.buzzer;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   // checks
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a transaction");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("no status after a transaction");

   a_buzzer_alarm: assert property (@(posedge clock) disable iff (reset)
      state_ff.buzzer |-> state_ff.mode == MODE_ALARM)
      else $error("buzzer on outside alarm mode");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.temp < 8'(TEMP_SCALE))
      else $error("temperature out of range");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      {30'd0, state_ff.digit_count} <= 32'(MAX_DIGITS))
      else $error("too many digits held");

endmodule

@@ sv/tac_scale.sv @@
module tac_scale (
   input  logic [tac_pkg::ADC_BITS-1:0] sample,
   output logic [7:0]                   temperature
);
   import tac_pkg::*;

   localparam int unsigned PROD_BITS = ADC_BITS + 8;

   logic [PROD_BITS-1:0] product;

   // temperature = sample * 150 >> ADC_BITS, always below 150
   assign product     = PROD_BITS'(sample) * PROD_BITS'(TEMP_SCALE);
   assign temperature = product[PROD_BITS-1 -: 8];

endmodule

@@ sv/tac_step.sv @@
module tac_step (
   input  tac_pkg::req_type   item,
   input  tac_pkg::state_type cur,
   output tac_pkg::state_type nxt
);
   import tac_pkg::*;

   logic [7:0] temperature;
   logic [7:0] key_digit;
   logic [7:0] ser_digit;
   logic [7:0] key_accum;
   logic [7:0] ser_accum;
   logic       room;
   logic       is_sample;
   logic       is_key;
   logic       is_serial;

   tac_scale u_scale (
      .sample      (item.sample),
      .temperature (temperature)
   );

   // digit values and accumulation, mod 256
   assign key_digit = (item.key_code == KEY_ZERO) ? 8'd0 : {4'd0, item.key_code};
   assign ser_digit = item.rx_byte - CHAR_ZERO;
   assign key_accum = (cur.entry_value * 8'd10) + key_digit;
   assign ser_accum = (cur.entry_value * 8'd10) + ser_digit;
   assign room      = {30'd0, cur.digit_count} < 32'(MAX_DIGITS);

   assign is_sample = item.kind == KIND_SAMPLE;
   assign is_key    = item.kind == KIND_KEY;
   assign is_serial = item.kind == KIND_SERIAL;

   // per-mode state update
   always_comb begin
      nxt = cur;
      case (cur.mode)
         MODE_MAIN: begin
            if (is_sample) begin
               nxt.temp = temperature;
               if (temperature > cur.limit && cur.enable) begin
                  nxt.mode = MODE_ALARM;
               end
            end else if (is_key) begin
               if (item.key_code == KEY_ENTER) begin
                  nxt.mode        = MODE_KEY;
                  nxt.digit_count = 2'd0;
                  nxt.entry_value = 8'd0;
               end else if (item.key_code == KEY_TOGGLE) begin
                  nxt.enable = ~cur.enable;
               end
            end else if (is_serial) begin
               if (item.rx_byte == CHAR_GO) begin
                  nxt.mode        = MODE_SER;
                  nxt.digit_count = 2'd0;
                  nxt.entry_value = 8'd0;
               end
            end
         end
         MODE_ALARM: begin
            if (is_sample) begin
               nxt.temp   = temperature;
               nxt.buzzer = ~cur.buzzer;
               if (temperature < cur.limit) begin
                  nxt.mode   = MODE_MAIN;
                  nxt.buzzer = 1'b0;
               end
            end else if ((is_key && item.key_code == KEY_SILENCE) ||
                         (is_serial && item.rx_byte == CHAR_STOP)) begin
               nxt.enable = 1'b0;
               nxt.buzzer = 1'b0;
               nxt.mode   = MODE_MAIN;
            end
         end
         MODE_KEY: begin
            if (is_key) begin
               if (item.key_code <= KEY_ZERO && room) begin
                  nxt.entry_value = key_accum;
                  nxt.digit_count = cur.digit_count + 2'd1;
               end else begin
                  if (item.key_code == KEY_ENTER) begin
                     nxt.limit = cur.entry_value;
                  end
                  nxt.mode        = MODE_MAIN;
                  nxt.digit_count = 2'd0;
                  nxt.entry_value = 8'd0;
               end
            end
         end
         MODE_SER: begin
            if (is_serial) begin
               if (item.rx_byte != CHAR_OK && item.rx_byte != CHAR_CANCEL && room) begin
                  nxt.entry_value = ser_accum;
                  nxt.digit_count = cur.digit_count + 2'd1;
               end else begin
                  if (item.rx_byte == CHAR_OK) begin
                     nxt.limit = cur.entry_value;
                  end
                  nxt.mode        = MODE_MAIN;
                  nxt.digit_count = 2'd0;
                  nxt.entry_value = 8'd0;
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule
